>>> hw/rtl/mvwm_pkg.sv
// ----------------------------------------------------------------------------
// mvwm_pkg: shared definitions for the muon veto window merger
// Field widths, register codes, hit kinds, fill actions and the compare
// request that the sequencer hands to the shared time compare unit.
// ----------------------------------------------------------------------------
package mvwm_pkg;

   // field widths
   localparam int TS_W      = 63;
   localparam int VAL_W     = 20;
   localparam int KIND_W    = 2;
   localparam int DET_SEL_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam int NUM_DETECTORS_DEF = 4;

   // register reset values
   localparam logic [VAL_W-1:0] MERGE_WIN_RESET  = 20'd5000;
   localparam logic [VAL_W-1:0] RETRIG_WIN_RESET = 20'd15000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_WIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRIG_WIN = 2'd1;

   // hit kinds
   localparam logic [KIND_W-1:0] KIND_POOL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DET  = 2'd2;

   // compare modes of the shared unit
   typedef enum logic {
      CMP_INSIDE_MERGE,
      CMP_PAST_DEAD
   } cmp_mode_type;

   typedef struct packed {
      logic [TS_W-1:0] now;
      logic [TS_W-1:0] stored;
      logic            seen;
      cmp_mode_type    mode;
   } cmp_req_type;

   // per-detector fill action decided in the scan pass
   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_POOL_ADD  = 3'd1,
      ACT_POOL_REPL = 3'd2,
      ACT_DET_ADD   = 3'd3,
      ACT_DET_REPL  = 3'd4
   } act_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DDEAD = 5'b00010,
      S_PMRG  = 5'b00100,
      S_PDEAD = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

endpackage

>>> hw/rtl/mvwm_if.sv
// ----------------------------------------------------------------------------
// mvwm_if: channel interfaces of the muon veto window merger
// Hit channel, fill record channel and register write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface mvwm_req_if;
   logic                          valid;
   logic                          ready;
   logic [mvwm_pkg::TS_W-1:0]     timestamp_ns;
   logic [mvwm_pkg::KIND_W-1:0]   hit_kind;
   logic [mvwm_pkg::DET_SEL_W-1:0] detector_index;
   logic [mvwm_pkg::VAL_W-1:0]    strength;

   modport source (output valid, timestamp_ns, hit_kind, detector_index, strength,
                   input ready);
   modport sink   (input valid, timestamp_ns, hit_kind, detector_index, strength,
                   output ready);
endinterface

interface mvwm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           to_detector_histogram;
   logic [mvwm_pkg::DET_SEL_W-1:0] fill_detector;
   logic [mvwm_pkg::VAL_W-1:0]     fill_value;
   logic                           fill_remove;
   logic                           last_fill;

   modport source (output valid, to_detector_histogram, fill_detector, fill_value,
                   fill_remove, last_fill, input ready);
   modport sink   (input valid, to_detector_histogram, fill_detector, fill_value,
                   fill_remove, last_fill, output ready);
endinterface

interface mvwm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mvwm_pkg::CSR_IDX_W-1:0] addr;
   logic [mvwm_pkg::VAL_W-1:0]     wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

>>> hw/rtl/muon_veto_window_merger_top.sv
// ----------------------------------------------------------------------------
// muon_veto_window_merger_top: muon veto window merger
// Turns time-stamped pool and detector hits into histogram fill words with
// add/remove weights, merging pool hits and applying retrigger deadtime.
//
// Usage:
//   req_ch  hit words in (timestamp, kind, detector, strength); valid/ready.
//   rsp_ch  fill words out; last_fill marks the final word of one hit.
//   csr_ch  register writes (0 merge window, 1 retrigger window, 20 bits);
//           always ready, write only while no hit is in flight.
// Sequencing: one hit at a time; req_ch.ready is high only in idle.
//   A pool hit makes one to three compares per detector, one a cycle on the
//   shared compare unit, then the emit pass steps through the detectors up
//   to the last with a fill (all of them when none has one), a remove word
//   before the add word where one is due; at most 2 * NUM_DETECTORS words.
//   A detector hit makes one or two compares and zero to two words.
//   Ignored kinds are dropped on accept; ready stays high.
// Reset: windows return to 5000 ns and 15000 ns, all seen flags clear.
// Stall: a held fill word freezes the emit pass until taken; after the final
//   word of a hit is loaded the next hit is accepted and scanned meanwhile.
// ----------------------------------------------------------------------------
module muon_veto_window_merger_top #(
   parameter int NUM_DETECTORS = mvwm_pkg::NUM_DETECTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mvwm_req_if.sink    req_ch,
   mvwm_rsp_if.source  rsp_ch,
   mvwm_csr_if.sink    csr_ch
);

   logic [mvwm_pkg::VAL_W-1:0] merge_win_ff, merge_win_in;
   logic [mvwm_pkg::VAL_W-1:0] retrig_win_ff, retrig_win_in;
   mvwm_pkg::cmp_req_type      cmp_req;
   logic                       cmp_hit;

   assign csr_ch.ready = 1'b1;

   // decode register writes
   always_comb begin
      merge_win_in  = merge_win_ff;
      retrig_win_in = retrig_win_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            mvwm_pkg::CSR_MERGE_WIN:  merge_win_in  = csr_ch.wdata;
            mvwm_pkg::CSR_RETRIG_WIN: retrig_win_in = csr_ch.wdata;
            default: begin
               merge_win_in  = merge_win_ff;
               retrig_win_in = retrig_win_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_win_ff  <= mvwm_pkg::MERGE_WIN_RESET;
         retrig_win_ff <= mvwm_pkg::RETRIG_WIN_RESET;
      end else begin
         merge_win_ff  <= merge_win_in;
         retrig_win_ff <= retrig_win_in;
      end
   end

   mvwm_cmp u_cmp (
      .cmp_req    (cmp_req),
      .merge_win  (merge_win_ff),
      .retrig_win (retrig_win_ff),
      .cmp_hit    (cmp_hit)
   );

   mvwm_ctrl #(
      .NUM_DETECTORS (NUM_DETECTORS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .cmp_req (cmp_req),
      .cmp_hit (cmp_hit)
   );

endmodule

>>> hw/rtl/mvwm_cmp.sv
// ----------------------------------------------------------------------------
// mvwm_cmp: shared time window compare unit
// One 63-bit subtract and a compare against the selected window; answers
// either "inside merge window" or "past retrigger deadtime".
// ----------------------------------------------------------------------------
module mvwm_cmp (
   input  mvwm_pkg::cmp_req_type          cmp_req,
   input  logic [mvwm_pkg::VAL_W-1:0]     merge_win,
   input  logic [mvwm_pkg::VAL_W-1:0]     retrig_win,
   output logic                           cmp_hit
);

   logic [mvwm_pkg::TS_W:0]    diff;
   logic                       backwards;
   logic                       high_zero;
   logic                       below_merge;
   logic                       above_retrig;

   // time since the stored hit; the borrow flags time going backwards
   assign diff      = {1'b0, cmp_req.now} - {1'b0, cmp_req.stored};
   assign backwards = diff[mvwm_pkg::TS_W];
   assign high_zero = (diff[mvwm_pkg::TS_W-1:mvwm_pkg::VAL_W] == '0);

   assign below_merge  = high_zero && (diff[mvwm_pkg::VAL_W-1:0] < merge_win);
   assign above_retrig = !high_zero || (diff[mvwm_pkg::VAL_W-1:0] > retrig_win);

   // select the rule
   always_comb begin
      case (cmp_req.mode)
         mvwm_pkg::CMP_INSIDE_MERGE: cmp_hit = cmp_req.seen && (backwards || below_merge);
         mvwm_pkg::CMP_PAST_DEAD:    cmp_hit = !cmp_req.seen || (!backwards && above_retrig);
         default:                    cmp_hit = 1'b0;
      endcase
   end

endmodule

>>> hw/rtl/mvwm_ctrl.sv
// ----------------------------------------------------------------------------
// mvwm_ctrl: sequencer, per-detector state and fill record output
// Scans the detectors one compare a cycle, stores a fill action per detector,
// then emits the fill words in order and updates the stored hits.
// ----------------------------------------------------------------------------
module mvwm_ctrl #(
   parameter int NUM_DETECTORS = mvwm_pkg::NUM_DETECTORS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   mvwm_req_if.sink                   req_ch,
   mvwm_rsp_if.source                 rsp_ch,
   output mvwm_pkg::cmp_req_type      cmp_req,
   input  logic                       cmp_hit
);

   localparam int IDX_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DETECTORS - 1);

   mvwm_pkg::state_type              state_ff, state_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic                             sub_ff, sub_in;
   mvwm_pkg::act_type                act_ff [NUM_DETECTORS];
   mvwm_pkg::act_type                act_in [NUM_DETECTORS];
   logic [mvwm_pkg::TS_W-1:0]        time_ff, time_in;
   logic [mvwm_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [mvwm_pkg::VAL_W-1:0]       str_ff, str_in;

   logic [mvwm_pkg::TS_W-1:0]        det_time_ff  [NUM_DETECTORS];
   logic                             det_seen_ff  [NUM_DETECTORS];
   logic [mvwm_pkg::TS_W-1:0]        pool_time_ff [NUM_DETECTORS];
   logic                             pool_seen_ff [NUM_DETECTORS];
   logic [mvwm_pkg::VAL_W-1:0]       pool_str_ff  [NUM_DETECTORS];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_to_det_ff, rsp_to_det_in;
   logic [mvwm_pkg::DET_SEL_W-1:0]   rsp_det_ff, rsp_det_in;
   logic [mvwm_pkg::VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                             rsp_remove_ff, rsp_remove_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             req_acc;
   logic                             out_free;
   logic                             rsp_load;
   logic                             later_any;
   logic                             act_any;
   logic                             is_last_idx;
   logic [IDX_W-1:0]                 idx_next;
   logic                             pool_upd, pool_set_seen, det_upd;
   mvwm_pkg::act_type                cur_act;

   assign req_ch.ready = (state_ff == mvwm_pkg::S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_last_idx  = (idx_ff == LAST_IDX);
   assign idx_next     = IDX_W'(idx_ff + 1'b1);
   assign cur_act      = act_ff[idx_ff];

   // look ahead for actions on later detectors
   always_comb begin
      later_any = 1'b0;
      act_any   = 1'b0;
      for (int j = 0; j < NUM_DETECTORS; j++) begin
         if (act_ff[j] != mvwm_pkg::ACT_NONE) begin
            act_any = 1'b1;
            if (j > int'(idx_ff)) begin
               later_any = 1'b1;
            end
         end
      end
   end

   // route the stored hit of the current detector to the compare unit
   always_comb begin
      cmp_req.now = time_ff;
      if (state_ff == mvwm_pkg::S_DDEAD) begin
         cmp_req.stored = det_time_ff[idx_ff];
         cmp_req.seen   = det_seen_ff[idx_ff];
         cmp_req.mode   = mvwm_pkg::CMP_PAST_DEAD;
      end else if (state_ff == mvwm_pkg::S_PMRG) begin
         cmp_req.stored = pool_time_ff[idx_ff];
         cmp_req.seen   = pool_seen_ff[idx_ff];
         cmp_req.mode   = mvwm_pkg::CMP_INSIDE_MERGE;
      end else begin
         cmp_req.stored = pool_time_ff[idx_ff];
         cmp_req.seen   = pool_seen_ff[idx_ff];
         cmp_req.mode   = mvwm_pkg::CMP_PAST_DEAD;
      end
   end

   // sequencer: scan pass, then emit pass
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      sub_in        = sub_ff;
      act_in        = act_ff;
      time_in       = time_ff;
      kind_in       = kind_ff;
      str_in        = str_ff;
      rsp_load      = 1'b0;
      rsp_to_det_in = rsp_to_det_ff;
      rsp_det_in    = rsp_det_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_remove_in = rsp_remove_ff;
      rsp_last_in   = rsp_last_ff;
      pool_upd      = 1'b0;
      pool_set_seen = 1'b0;
      det_upd       = 1'b0;

      unique case (state_ff)
         mvwm_pkg::S_IDLE: begin
            if (req_acc) begin
               time_in = req_ch.timestamp_ns;
               kind_in = req_ch.hit_kind;
               str_in  = req_ch.strength;
               sub_in  = 1'b0;
               for (int j = 0; j < NUM_DETECTORS; j++) begin
                  act_in[j] = mvwm_pkg::ACT_NONE;
               end
               if (req_ch.hit_kind == mvwm_pkg::KIND_POOL) begin
                  idx_in   = '0;
                  state_in = mvwm_pkg::S_DDEAD;
               end else if (req_ch.hit_kind == mvwm_pkg::KIND_DET &&
                            32'(req_ch.detector_index) < NUM_DETECTORS) begin
                  idx_in   = IDX_W'(req_ch.detector_index);
                  state_in = mvwm_pkg::S_DDEAD;
               end
            end
         end

         mvwm_pkg::S_DDEAD: begin
            if (cmp_hit) begin
               state_in = mvwm_pkg::S_PMRG;
            end else if (kind_ff == mvwm_pkg::KIND_DET) begin
               state_in = mvwm_pkg::S_IDLE;
            end else if (is_last_idx) begin
               idx_in   = '0;
               state_in = mvwm_pkg::S_EMIT;
            end else begin
               idx_in = idx_next;
            end
         end

         mvwm_pkg::S_PMRG: begin
            if (kind_ff == mvwm_pkg::KIND_DET) begin
               act_in[idx_ff] = cmp_hit ? mvwm_pkg::ACT_DET_REPL : mvwm_pkg::ACT_DET_ADD;
               state_in       = mvwm_pkg::S_EMIT;
            end else if (cmp_hit) begin
               act_in[idx_ff] = (str_ff > pool_str_ff[idx_ff]) ?
                                mvwm_pkg::ACT_POOL_REPL : mvwm_pkg::ACT_NONE;
               if (is_last_idx) begin
                  idx_in   = '0;
                  state_in = mvwm_pkg::S_EMIT;
               end else begin
                  idx_in   = idx_next;
                  state_in = mvwm_pkg::S_DDEAD;
               end
            end else begin
               state_in = mvwm_pkg::S_PDEAD;
            end
         end

         mvwm_pkg::S_PDEAD: begin
            act_in[idx_ff] = cmp_hit ? mvwm_pkg::ACT_POOL_ADD : mvwm_pkg::ACT_NONE;
            if (is_last_idx) begin
               idx_in   = '0;
               state_in = mvwm_pkg::S_EMIT;
            end else begin
               idx_in   = idx_next;
               state_in = mvwm_pkg::S_DDEAD;
            end
         end

         mvwm_pkg::S_EMIT: begin
            if (cur_act == mvwm_pkg::ACT_NONE) begin
               // skip detectors with nothing to fill
               if (is_last_idx) begin
                  state_in = mvwm_pkg::S_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end else if (out_free) begin
               rsp_load   = 1'b1;
               rsp_det_in = mvwm_pkg::DET_SEL_W'(idx_ff);
               if ((cur_act == mvwm_pkg::ACT_POOL_REPL || cur_act == mvwm_pkg::ACT_DET_REPL)
                   && !sub_ff) begin
                  // remove the stored pool entry first
                  rsp_to_det_in = 1'b0;
                  rsp_value_in  = pool_str_ff[idx_ff];
                  rsp_remove_in = 1'b1;
                  rsp_last_in   = 1'b0;
                  sub_in        = 1'b1;
               end else begin
                  rsp_to_det_in = (cur_act == mvwm_pkg::ACT_DET_ADD ||
                                   cur_act == mvwm_pkg::ACT_DET_REPL);
                  rsp_value_in  = str_ff;
                  rsp_remove_in = 1'b0;
                  rsp_last_in   = !later_any;
                  sub_in        = 1'b0;
                  pool_upd      = (cur_act == mvwm_pkg::ACT_POOL_ADD ||
                                   cur_act == mvwm_pkg::ACT_POOL_REPL);
                  pool_set_seen = (cur_act == mvwm_pkg::ACT_POOL_ADD);
                  det_upd       = rsp_to_det_in;
                  if (is_last_idx || !later_any) begin
                     state_in = mvwm_pkg::S_IDLE;
                  end else begin
                     idx_in = idx_next;
                  end
               end
            end
         end

         default: begin
            state_in = mvwm_pkg::S_IDLE;
         end
      endcase
   end

   // output word valid: load, or drop once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvwm_pkg::S_IDLE;
         idx_ff       <= '0;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_DETECTORS; j++) begin
            act_ff[j]       <= mvwm_pkg::ACT_NONE;
            det_seen_ff[j]  <= 1'b0;
            pool_seen_ff[j] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
         if (det_upd) begin
            det_seen_ff[idx_ff] <= 1'b1;
         end
         if (pool_set_seen) begin
            pool_seen_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // payload registers and stored hit times
   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      kind_ff       <= kind_in;
      str_ff        <= str_in;
      rsp_to_det_ff <= rsp_to_det_in;
      rsp_det_ff    <= rsp_det_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_remove_ff <= rsp_remove_in;
      rsp_last_ff   <= rsp_last_in;
      if (det_upd) begin
         det_time_ff[idx_ff] <= time_ff;
      end
      if (pool_upd) begin
         pool_time_ff[idx_ff] <= time_ff;
         pool_str_ff[idx_ff]  <= str_ff;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.to_detector_histogram = rsp_to_det_ff;
   assign rsp_ch.fill_detector         = rsp_det_ff;
   assign rsp_ch.fill_value            = rsp_value_ff;
   assign rsp_ch.fill_remove           = rsp_remove_ff;
   assign rsp_ch.last_fill             = rsp_last_ff;

   // the final word of an item returns the sequencer to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == mvwm_pkg::S_IDLE))
      else $error("last fill word did not end the item");

   // detector index stays in range
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(idx_ff) < NUM_DETECTORS)
      else $error("detector index out of range");

   // a new hit starts with no pending actions
   a_act_clear: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !act_any)
      else $error("stale fill action after accepting a hit");

   // no word is loaded over one that is still stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !rsp_load)
      else $error("fill word overwritten while stalled");

endmodule
